### rtl/xzd_pkg.sv
// Shared constants and types for the Montgomery x:z point doubling core.
package xzd_pkg;

   localparam int WORD_BITS_DEF = 64;
   localparam int SHIFT_BITS = 6;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS = 2'd0,
      CSR_A24     = 2'd1,
      CSR_SHIFT   = 2'd2,
      CSR_RECIP   = 2'd3
   } csr_index_type;

endpackage

### rtl/xzd_if.sv
// Request and response channel interfaces of the point doubling core.
interface xzd_req_if #(parameter int W = 64);
   logic         valid;
   logic         ready;
   logic [W-1:0] x_in;
   logic [W-1:0] z_in;
   modport source (output valid, output x_in, output z_in, input ready);
   modport sink (input valid, input x_in, input z_in, output ready);
endinterface

interface xzd_rsp_if #(parameter int W = 64);
   logic         valid;
   logic         ready;
   logic [W-1:0] x_out;
   logic [W-1:0] z_out;
   modport source (output valid, output x_out, output z_out, input ready);
   modport sink (input valid, input x_out, input z_out, output ready);
endinterface

### rtl/montgomery_xz_point_double_core.sv
// Montgomery-curve x:z point doubling core built from three pipelined modular multipliers.
// Takes one transaction per clock and returns one per clock when the response side keeps
// ready high. Each of the three dependent multiply levels spends WORD_BITS stages
// reducing the shifted first operand and WORD_BITS stages on the bit-serial multiply,
// with one compare-subtract step per reduction stage and two per multiply stage,
// plus seven register stages for the additions and hand-off. A stalled response
// freezes the whole pipeline; nothing is dropped. A zero z passes through as (x, 0).
// Write the configuration registers only while no transaction is in flight.
module montgomery_xz_point_double_core
   import xzd_pkg::*;
#(
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   xzd_req_if.sink              req_if,
   xzd_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  csr_index_type        csr_index,
   input  logic [WORD_BITS-1:0] csr_wdata
);

   localparam int W = WORD_BITS;

   function automatic logic [W-1:0] add_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] n);
      logic [W-1:0] d;
      d = n - y;
      add_m = (d > x) ? x + y : x + y - n;
   endfunction

   function automatic logic [W-1:0] sub_m(input logic [W-1:0] x, input logic [W-1:0] y,
                                          input logic [W-1:0] n);
      sub_m = (y > x) ? x - y + n : x - y;
   endfunction

   logic [W-1:0]            modulus_ff;
   logic [W-1:0]            a24_ff;
   logic [SHIFT_BITS-1:0]   shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= '0;
         a24_ff <= '0;
         shift_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata;
            CSR_A24:     a24_ff <= csr_wdata;
            CSR_SHIFT:   shift_ff <= csr_wdata[SHIFT_BITS-1:0];
            CSR_RECIP:   ;
            default:     ;
         endcase
      end
   end

   logic advance;
   logic rsp_valid_ff;
   assign advance = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = advance;

   // entry stage
   logic         a_valid_ff;
   logic [W-1:0] a_u_ff, a_v_ff, a_x0_ff;
   logic         a_inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_u_ff <= add_m(req_if.x_in, req_if.z_in, modulus_ff);
         a_v_ff <= sub_m(req_if.x_in, req_if.z_in, modulus_ff);
         a_x0_ff <= req_if.x_in;
         a_inf_ff <= (req_if.z_in == '0);
      end
   end

   // square u and v
   logic              l1_valid;
   logic [1:0][W-1:0] l1_p;
   logic [W:0]        l1_side;

   xzd_mulmod #(.W(W), .LANES(2), .SIDE_BITS(W + 1)) u_mul_sq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (a_valid_ff),
      .in_a       ({a_v_ff, a_u_ff}),
      .in_b       ({a_v_ff, a_u_ff}),
      .in_side    ({a_inf_ff, a_x0_ff}),
      .norm_shift (shift_ff),
      .modulus    (modulus_ff),
      .out_valid  (l1_valid),
      .out_p      (l1_p),
      .out_side   (l1_side)
   );

   logic         b_valid_ff;
   logic [W-1:0] b_u_ff, b_v_ff, b_w_ff, b_x0_ff;
   logic         b_inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= l1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_u_ff <= l1_p[0];
         b_v_ff <= l1_p[1];
         b_w_ff <= sub_m(l1_p[0], l1_p[1], modulus_ff);
         b_x0_ff <= l1_side[W-1:0];
         b_inf_ff <= l1_side[W];
      end
   end

   // u*v and w*a24
   logic              l2_valid;
   logic [1:0][W-1:0] l2_p;
   logic [3*W:0]      l2_side;

   xzd_mulmod #(.W(W), .LANES(2), .SIDE_BITS(3 * W + 1)) u_mul_mid (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (b_valid_ff),
      .in_a       ({b_w_ff, b_u_ff}),
      .in_b       ({a24_ff, b_v_ff}),
      .in_side    ({b_v_ff, b_w_ff, b_inf_ff, b_x0_ff}),
      .norm_shift (shift_ff),
      .modulus    (modulus_ff),
      .out_valid  (l2_valid),
      .out_p      (l2_p),
      .out_side   (l2_side)
   );

   logic         c_valid_ff;
   logic [W-1:0] c_t_ff, c_w_ff, c_xo_ff, c_x0_ff;
   logic         c_inf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= l2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_t_ff <= add_m(l2_p[1], l2_side[3*W:2*W+1], modulus_ff);
         c_w_ff <= l2_side[2*W:W+1];
         c_xo_ff <= l2_p[0];
         c_x0_ff <= l2_side[W-1:0];
         c_inf_ff <= l2_side[W];
      end
   end

   // w*t
   logic              l3_valid;
   logic [0:0][W-1:0] l3_p;
   logic [2*W:0]      l3_side;

   xzd_mulmod #(.W(W), .LANES(1), .SIDE_BITS(2 * W + 1)) u_mul_z (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (c_valid_ff),
      .in_a       (c_w_ff),
      .in_b       (c_t_ff),
      .in_side    ({c_xo_ff, c_inf_ff, c_x0_ff}),
      .norm_shift (shift_ff),
      .modulus    (modulus_ff),
      .out_valid  (l3_valid),
      .out_p      (l3_p),
      .out_side   (l3_side)
   );

   logic [W-1:0] x_out_ff, z_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= l3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_out_ff <= l3_side[W] ? l3_side[W-1:0] : l3_side[2*W:W+1];
         z_out_ff <= l3_side[W] ? '0 : l3_p[0];
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.x_out = x_out_ff;
   assign rsp_if.z_out = z_out_ff;

endmodule

### rtl/xzd_mulmod.sv
// Pipelined modular multiplier: ((a >> shift) * b) mod n, one bit per stage.
module xzd_mulmod
   import xzd_pkg::*;
#(
   parameter int W = WORD_BITS_DEF,
   parameter int LANES = 1,
   parameter int SIDE_BITS = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [LANES-1:0][W-1:0]       in_a,
   input  logic [LANES-1:0][W-1:0]       in_b,
   input  logic [SIDE_BITS-1:0]          in_side,
   input  logic [SHIFT_BITS-1:0]         norm_shift,
   input  logic [W-1:0]                  modulus,
   output logic                          out_valid,
   output logic [LANES-1:0][W-1:0]       out_p,
   output logic [SIDE_BITS-1:0]          out_side
);

   localparam int DEPTH = 2 * W;

   logic                    valid_ff [0:DEPTH];
   logic [LANES-1:0][W-1:0] acc_ff   [0:DEPTH];
   logic [LANES-1:0][W-1:0] opa_ff   [0:DEPTH];
   logic [LANES-1:0][W-1:0] opb_ff   [0:DEPTH];
   logic [SIDE_BITS-1:0]    side_ff  [0:DEPTH];

   logic [W:0] mod_ext;
   assign mod_ext = {1'b0, modulus};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < LANES; l++) begin
            acc_ff[0][l] <= '0;
            opa_ff[0][l] <= in_a[l] >> norm_shift;
            opb_ff[0][l] <= in_b[l];
         end
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 1; j <= DEPTH; j++) begin : g_stage
      logic [LANES-1:0][W-1:0] acc_in;
      logic [LANES-1:0][W-1:0] opa_in;

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         if (j <= W) begin : g_reduce
            logic [W:0] rem2;
            logic [W:0] rem2_sub;
            always_comb begin
               rem2 = {acc_ff[j-1][l], opa_ff[j-1][l][W-j]};
               rem2_sub = rem2 - mod_ext;
               acc_in[l] = (rem2 >= mod_ext) ? rem2_sub[W-1:0] : rem2[W-1:0];
               opa_in[l] = opa_ff[j-1][l];
            end
         end else begin : g_mul
            localparam int BIT = DEPTH - j;
            logic [W-1:0] r_prev;
            logic [W-1:0] ar;
            logic [W:0]   dbl;
            logic [W:0]   dbl_sub;
            logic [W-1:0] dbl_red;
            logic [W:0]   sum;
            logic [W:0]   sum_sub;
            always_comb begin
               r_prev = (j == W + 1) ? '0 : acc_ff[j-1][l];
               ar = (j == W + 1) ? acc_ff[j-1][l] : opa_ff[j-1][l];
               dbl = {r_prev, 1'b0};
               dbl_sub = dbl - mod_ext;
               dbl_red = (dbl >= mod_ext) ? dbl_sub[W-1:0] : dbl[W-1:0];
               sum = {1'b0, dbl_red} + (opb_ff[j-1][l][BIT] ? {1'b0, ar} : '0);
               sum_sub = sum - mod_ext;
               acc_in[l] = (sum >= mod_ext) ? sum_sub[W-1:0] : sum[W-1:0];
               opa_in[l] = ar;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            acc_ff[j]  <= acc_in;
            opa_ff[j]  <= opa_in;
            opb_ff[j]  <= opb_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[DEPTH];
   assign out_side = side_ff[DEPTH];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_p[l] = (modulus == '0) ? '0 : acc_ff[DEPTH][l];
      end
   end

endmodule

### rtl/xzd_checker.sv
// Port-level assertions for the point doubling core, bound to the top level.
module xzd_checker
   import xzd_pkg::*;
#(
   parameter int W = WORD_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input logic [W-1:0] rsp_x,
   input logic [W-1:0] rsp_z
);

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response slot");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_x) && $stable(rsp_z))
      else $error("response payload changed while stalled");

endmodule

bind montgomery_xz_point_double_core xzd_checker #(.W(WORD_BITS)) u_xzd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_x     (rsp_if.x_out),
   .rsp_z     (rsp_if.z_out)
);

### test/montgomery_xz_point_double_core_test.sv
// Self-checking testbench for the Montgomery x:z point doubling core.
module montgomery_xz_point_double_core_test;
   import xzd_pkg::*;

   localparam int W = 64;
   localparam int LATENCY = 6 * W + 7;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [W-1:0] ONES = '1;

   typedef struct {
      logic [W-1:0] x;
      logic [W-1:0] z;
   } point_type;

   typedef struct {
      logic [W-1:0] x;
      logic [W-1:0] z;
      bit           known;
      logic [W-1:0] ex;
      logic [W-1:0] ez;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_MODULUS;
   logic [W-1:0] csr_wdata = '0;

   xzd_req_if #(W) req ();
   xzd_rsp_if #(W) rsp ();

   logic [W-1:0] modulus_q = '0;
   logic [W-1:0] a24_q = '0;
   logic [5:0]   shift_q = '0;

   point_type doubled_q[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   int rsp_stall = 0;

   montgomery_xz_point_double_core #(.WORD_BITS(W)) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req),
      .rsp_if(rsp),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [W-1:0] mod_add(logic [W-1:0] a, logic [W-1:0] b);
      logic [W-1:0] d;
      d = modulus_q - b;
      return (d > a) ? a + b : a + b - modulus_q;
   endfunction

   function automatic logic [W-1:0] mod_sub(logic [W-1:0] a, logic [W-1:0] b);
      return (b > a) ? a - b + modulus_q : a - b;
   endfunction

   function automatic logic [W-1:0] mod_mul(logic [W-1:0] a, logic [W-1:0] b);
      logic [2*W-1:0] p;
      if (modulus_q == '0) return '0;
      p = {{W{1'b0}}, a >> shift_q} * {{W{1'b0}}, b};
      p = p % {{W{1'b0}}, modulus_q};
      return p[W-1:0];
   endfunction

   function automatic point_type double_point(logic [W-1:0] x, logic [W-1:0] z);
      point_type r;
      logic [W-1:0] u, v, w, t;
      if (z == '0) begin
         r.x = x;
         r.z = '0;
         return r;
      end
      u = mod_add(x, z);
      u = mod_mul(u, u);
      v = mod_sub(x, z);
      v = mod_mul(v, v);
      r.x = mod_mul(u, v);
      w = mod_sub(u, v);
      t = mod_mul(w, a24_q);
      t = mod_add(t, v);
      r.z = mod_mul(w, t);
      return r;
   endfunction

   function automatic logic [W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [W-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return rand_word();
         1: return ONES;
         2: return '0;
         3: return W'($urandom_range(1, 16));
         default: return (modulus_q == '0) ? rand_word() : rand_word() % modulus_q;
      endcase
   endfunction

   function automatic int draw_gap();
      return quiet ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic csr_write(csr_index_type idx, logic [W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MODULUS: modulus_q = val;
         CSR_A24:     a24_q = val;
         CSR_SHIFT:   shift_q = val[5:0];
         default:     ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(logic [W-1:0] n, logic [W-1:0] a24, logic [5:0] sh);
      csr_write(CSR_MODULUS, n);
      csr_write(CSR_A24, a24);
      csr_write(CSR_SHIFT, W'(sh));
      csr_write(CSR_RECIP, rand_word());
   endtask

   task automatic drain();
      while (doubled_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   // Drive one transaction and record its expected doubling at acceptance.
   task automatic send_point(logic [W-1:0] x, logic [W-1:0] z, bit known,
                             logic [W-1:0] ex, logic [W-1:0] ez);
      int gap;
      point_type p;
      gap = draw_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.x_in <= x;
      req.z_in <= z;
      do @(posedge clock); while (!req.ready);
      if (known) begin
         p.x = ex;
         p.z = ez;
      end else begin
         p = double_point(x, z);
      end
      doubled_q.push_back(p);
   endtask

   task automatic idle_sender();
      req.valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         rsp.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (doubled_q.size() == 0) begin
               $error("unexpected transaction x_out=%h z_out=%h", rsp.x_out, rsp.z_out);
               errors++;
            end else begin
               e = doubled_q.pop_front();
               if (rsp.x_out !== e.x) begin
                  $error("x_out expected %h actual %h", e.x, rsp.x_out);
                  errors++;
               end
               if (rsp.z_out !== e.z) begin
                  $error("z_out expected %h actual %h", e.z, rsp.z_out);
                  errors++;
               end
            end
            rsp_stall = draw_gap();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("montgomery_xz_point_double_core_test failed");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      logic [W-1:0] n0;
      logic [W-1:0] x, z;
      int k;
      req.valid = 1'b0;
      req.x_in = '0;
      req.z_in = '0;
      n0 = 64'hF123_4567_89AB_CDEF;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      configure(n0, 64'h0000_0000_0001_2345, 6'd3);

      rows = '{
         '{'0, '0, 1, '0, '0},
         '{ONES, '0, 1, ONES, '0},
         '{64'h1234_5678_9ABC_DEF0, '0, 1, 64'h1234_5678_9ABC_DEF0, '0},
         '{'0, 64'd1, 0, '0, '0},
         '{64'd1, 64'd1, 0, '0, '0},
         '{64'd1, 64'd2, 0, '0, '0},
         '{ONES, ONES, 0, '0, '0},
         '{'0, ONES, 0, '0, '0},
         '{ONES, 64'd1, 0, '0, '0},
         '{n0 - 1, 64'd1, 0, '0, '0},
         '{64'd1, n0 - 1, 0, '0, '0},
         '{n0 - 1, n0 - 1, 0, '0, '0},
         '{n0, n0, 0, '0, '0},
         '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 0, '0, '0},
         '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, '0},
         '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 0, '0, '0}
      };
      foreach (rows[i])
         send_point(rows[i].x, rows[i].z, rows[i].known, rows[i].ex, rows[i].ez);
      idle_sender();
      // hold the sender until the pipeline has emptied
      drain();

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: configure(ONES, ONES, 6'd0);
            1: configure(64'h8000_0000_0000_0000, '0, 6'd63);
            2: configure('0, rand_word(), 6'($urandom_range(0, 63)));
            3: configure(64'hFFFF_FFFF_FFFF_FFC5, 64'd1, 6'd0);
            4: configure(rand_word(), rand_word(), 6'($urandom_range(0, 63)));
            default: configure(rand_word() | 64'h8000_0000_0000_0000, rand_word(),
                               6'($urandom_range(0, 63)));
         endcase
         for (k = 0; k < 50; k++) begin
            if (k % 20 == 0) quiet = ($urandom_range(0, 2) == 0);
            x = pick_coord();
            z = ($urandom_range(0, 9) == 0) ? '0 : pick_coord();
            send_point(x, z, 0, '0, '0);
         end
         quiet = 1'b0;
         idle_sender();
         drain();
      end

      if (errors == 0) begin
         $display("montgomery_xz_point_double_core_test passed");
      end else begin
         $display("montgomery_xz_point_double_core_test failed");
      end
      $finish;
   end

   final begin
      if (doubled_q.size() != 0)
         $error("%0d expected transactions never arrived", doubled_q.size());
   end

endmodule

### files.f
rtl/xzd_pkg.sv
rtl/xzd_if.sv
rtl/xzd_mulmod.sv
rtl/montgomery_xz_point_double_core.sv
rtl/xzd_checker.sv
test/montgomery_xz_point_double_core_test.sv
